/* design/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/vrc_pkg.sv */
// ----------------------------------------------------------------------------
// vrc_pkg
// Types, widths and register codes for the vertex rotation pipeline.
// ----------------------------------------------------------------------------
package vrc_pkg;

  localparam int CRD_W     = 32;  // Q16.16 coordinate
  localparam int CFG_W     = 32;  // config data width
  localparam int CFG_IDX_W = 3;   // config register index
  localparam int COEF_W    = 16;  // Q1.14 cos / sin
  localparam int FRAC_W    = 14;  // fraction bits of the coefficients
  localparam int ACC_W     = 40;  // exact intermediate coordinate
  localparam int PROD_W    = ACC_W + COEF_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int SAT_W     = ACC_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_COS_SIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COS_SIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_COS_SIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = 3'd5;

  // cos = 1.0, sin = 0.0
  localparam logic [CFG_W-1:0] COS_SIN_RESET = 32'h4000_0000;

  typedef struct packed {
    logic signed [CRD_W-1:0] vertex_x;
    logic signed [CRD_W-1:0] vertex_y;
    logic signed [CRD_W-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] moved_x;
    logic signed [CRD_W-1:0] moved_y;
    logic signed [CRD_W-1:0] moved_z;
  } moved_t;

  // Two coordinates to rotate plus the one left alone by this axis
  typedef struct packed {
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] side;
  } acc_vec_t;

endpackage

/* design/vrc_axis_rot.sv */
// ----------------------------------------------------------------------------
// vrc_axis_rot
// One axis rotation: a' = R(c*a - s*b), b' = R(s*a + c*b), two register stages.
// ----------------------------------------------------------------------------
module vrc_axis_rot import vrc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] cos_sin,
  input  logic             src_valid,
  output logic             src_ready,
  input  acc_vec_t         src,
  output logic             dst_valid,
  input  logic             dst_ready,
  output acc_vec_t         dst
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_W - 1);

  logic signed [COEF_W-1:0] coef_c;
  logic signed [COEF_W-1:0] coef_s;

  // product stage
  logic                     a_valid;
  logic                     a_ready;
  logic signed [PROD_W-1:0] prod_ca;
  logic signed [PROD_W-1:0] prod_sb;
  logic signed [PROD_W-1:0] prod_sa;
  logic signed [PROD_W-1:0] prod_cb;
  logic signed [ACC_W-1:0]  side_a;

  // sum and round stage
  logic                     b_ready;
  logic signed [SUM_W-1:0]  sum_p;
  logic signed [SUM_W-1:0]  sum_q;

  assign coef_c = $signed(cos_sin[CFG_W-1 -: COEF_W]);
  assign coef_s = $signed(cos_sin[COEF_W-1:0]);

  // stage advances when empty or when the next one takes its word
  assign b_ready   = !dst_valid || dst_ready;
  assign a_ready   = !a_valid || b_ready;
  assign src_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= src_valid;
      if (b_ready) dst_valid <= a_valid;
    end
  end

  // four products, registered
  always_ff @(posedge clk) begin
    if (a_ready && src_valid) begin
      prod_ca <= coef_c * src.a;
      prod_sb <= coef_s * src.b;
      prod_sa <= coef_s * src.a;
      prod_cb <= coef_c * src.b;
      side_a  <= src.side;
    end
  end

  // exact sums with round-half-up, then drop the fraction
  assign sum_p = SUM_W'(prod_ca) - SUM_W'(prod_sb) + HALF;
  assign sum_q = SUM_W'(prod_sa) + SUM_W'(prod_cb) + HALF;

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      dst.a    <= sum_p[FRAC_W+ACC_W-1:FRAC_W];
      dst.b    <= sum_q[FRAC_W+ACC_W-1:FRAC_W];
      dst.side <= side_a;
    end
  end

endmodule

/* design/vertex_rotate_about_center_unit.sv */
// ----------------------------------------------------------------------------
// vertex_rotate_about_center_unit: eight register stages, two per axis multiply.
// Throughput one vertex per cycle while moved_stall is low.
// Reset clears all stage valids and loads cos = 1.0, sin = 0.0, center = 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_rotate_about_center_unit import vrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 vertex_valid,
  output logic                 vertex_stall,
  input  vertex_t              vertex,
  output logic                 moved_valid,
  input  logic                 moved_stall,
  output moved_t               moved
);

  logic [CFG_W-1:0]        x_cos_sin;
  logic [CFG_W-1:0]        y_cos_sin;
  logic [CFG_W-1:0]        z_cos_sin;
  logic signed [CRD_W-1:0] center_x;
  logic signed [CRD_W-1:0] center_y;
  logic signed [CRD_W-1:0] center_z;

  logic     s0_valid;
  logic     s0_ready;
  acc_vec_t s0_d;

  logic     x_ready;
  logic     x_valid;
  acc_vec_t x_out;
  logic     y_ready;
  logic     y_valid;
  acc_vec_t y_out;
  logic     z_ready_w;
  logic     z_valid;
  acc_vec_t z_out;
  acc_vec_t y_in;
  acc_vec_t z_in;

  logic     out_ready;

  function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-CRD_W:0] top;
    top = v[SAT_W-1:CRD_W-1];
    if (top == '0 || top == '1) begin
      sat_crd = v[CRD_W-1:0];
    end else if (v[SAT_W-1]) begin
      sat_crd = {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      sat_crd = {1'b0, {(CRD_W-1){1'b1}}};
    end
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_cos_sin <= COS_SIN_RESET;
      y_cos_sin <= COS_SIN_RESET;
      z_cos_sin <= COS_SIN_RESET;
      center_x  <= '0;
      center_y  <= '0;
      center_z  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_COS_SIN: x_cos_sin <= cfg_data;
        REG_Y_COS_SIN: y_cos_sin <= cfg_data;
        REG_Z_COS_SIN: z_cos_sin <= cfg_data;
        REG_CENTER_X:  center_x  <= $signed(cfg_data);
        REG_CENTER_Y:  center_y  <= $signed(cfg_data);
        REG_CENTER_Z:  center_z  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // stage 0: offset from center, exact
  assign s0_ready     = !s0_valid || x_ready;
  assign vertex_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= vertex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && vertex_valid) begin
      s0_d.a    <= ACC_W'(vertex.vertex_y) - ACC_W'(center_y);
      s0_d.b    <= ACC_W'(vertex.vertex_z) - ACC_W'(center_z);
      s0_d.side <= ACC_W'(vertex.vertex_x) - ACC_W'(center_x);
    end
  end

  // X axis: a = dy, b = dz -> y1, z1; x passes
  vrc_axis_rot u_rot_x (
    .clk       (clk),
    .rst       (rst),
    .cos_sin   (x_cos_sin),
    .src_valid (s0_valid),
    .src_ready (x_ready),
    .src       (s0_d),
    .dst_valid (x_valid),
    .dst_ready (y_ready),
    .dst       (x_out)
  );

  // Y axis: a = z1, b = x1 -> z2, x2; y1 passes
  assign y_in.a    = x_out.b;
  assign y_in.b    = x_out.side;
  assign y_in.side = x_out.a;

  vrc_axis_rot u_rot_y (
    .clk       (clk),
    .rst       (rst),
    .cos_sin   (y_cos_sin),
    .src_valid (x_valid),
    .src_ready (y_ready),
    .src       (y_in),
    .dst_valid (y_valid),
    .dst_ready (z_ready_w),
    .dst       (y_out)
  );

  // Z axis: a = x2, b = y1 -> x3, y3; z2 passes
  assign z_in.a    = y_out.b;
  assign z_in.b    = y_out.side;
  assign z_in.side = y_out.a;

  vrc_axis_rot u_rot_z (
    .clk       (clk),
    .rst       (rst),
    .cos_sin   (z_cos_sin),
    .src_valid (y_valid),
    .src_ready (z_ready_w),
    .src       (z_in),
    .dst_valid (z_valid),
    .dst_ready (out_ready),
    .dst       (z_out)
  );

  // output stage: add center back, saturate
  assign out_ready = !moved_valid || !moved_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      moved_valid <= 1'b0;
    end else if (out_ready) begin
      moved_valid <= z_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && z_valid) begin
      moved.moved_x <= sat_crd(SAT_W'(z_out.a) + SAT_W'(center_x));
      moved.moved_y <= sat_crd(SAT_W'(z_out.b) + SAT_W'(center_y));
      moved.moved_z <= sat_crd(SAT_W'(z_out.side) + SAT_W'(center_z));
    end
  end

  // an open output lets every stage move, so the input is never held
  `ASSERT_IMPLIES(a_open_out_no_stall, clk, rst, !moved_stall, !vertex_stall)
  // an accepted word lands in stage 0
  `ASSERT_NEXT(a_accept_fills_s0, clk, rst, vertex_valid && !vertex_stall, s0_valid)
  // a blocked stage 0 keeps its word
  `ASSERT_NEXT(a_s0_hold, clk, rst, s0_valid && !s0_ready, s0_valid && $stable(s0_d))

endmodule

/* tb/vertex_rotate_about_center_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_about_center_unit_tb
// Streams Q16.16 vertices through the rotation pipeline under a range of
// axis coefficient and center settings, predicts each moved vertex in the
// bench and compares every output word field by field, with random stalls
// on both sides, a long output hold-off and a full-rate final stretch.
// ----------------------------------------------------------------------------
module vertex_rotate_about_center_unit_tb import vrc_pkg::*; ();

  localparam int LATENCY        = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF       = 80;

  // Index codes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum {SET_IDENTITY, SET_ANGLES, SET_RAW, SET_EXTREME} setting_e;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 vertex_valid;
  logic                 vertex_stall;
  vertex_t              vertex;
  logic                 moved_valid;
  logic                 moved_stall = 1'b0;
  moved_t               moved;

  // Bench copy of the register file
  logic [CFG_W-1:0]        axis_cs [3];
  logic signed [CRD_W-1:0] center_q [3];

  moved_t moved_expected [$];
  int     error_count   = 0;
  int     send_gap_pct  = 0;
  int     recv_gap_pct  = 0;
  int     hold_request  = 0;
  int     hold_left     = 0;
  int     stall_left    = 0;
  int     quiet_cycles  = 0;

  vertex_rotate_about_center_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .moved_valid  (moved_valid),
    .moved_stall  (moved_stall),
    .moved        (moved)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Q1.14 product sum back to the coordinate scale, nearest, ties upward
  function automatic longint round_q14(longint p);
    return (p + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic logic signed [CRD_W-1:0] clamp_q16(longint s);
    if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic longint cos_of(logic [CFG_W-1:0] r);
    return longint'($signed(r[31:16]));
  endfunction

  function automatic longint sin_of(logic [CFG_W-1:0] r);
    return longint'($signed(r[15:0]));
  endfunction

  // Offset from center, X then Y then Z rotation, center added back
  function automatic moved_t rotate_about_center(vertex_t v);
    longint dx, dy, dz, y1, z1, x2, z2, x3, y3;
    moved_t r;
    dx = longint'(v.vertex_x) - longint'(center_q[0]);
    dy = longint'(v.vertex_y) - longint'(center_q[1]);
    dz = longint'(v.vertex_z) - longint'(center_q[2]);
    y1 = round_q14(cos_of(axis_cs[0]) * dy - sin_of(axis_cs[0]) * dz);
    z1 = round_q14(sin_of(axis_cs[0]) * dy + cos_of(axis_cs[0]) * dz);
    x2 = round_q14(cos_of(axis_cs[1]) * dx + sin_of(axis_cs[1]) * z1);
    z2 = round_q14(cos_of(axis_cs[1]) * z1 - sin_of(axis_cs[1]) * dx);
    x3 = round_q14(cos_of(axis_cs[2]) * x2 - sin_of(axis_cs[2]) * y1);
    y3 = round_q14(sin_of(axis_cs[2]) * x2 + cos_of(axis_cs[2]) * y1);
    r.moved_x = clamp_q16(x3 + longint'(center_q[0]));
    r.moved_y = clamp_q16(y3 + longint'(center_q[1]));
    r.moved_z = clamp_q16(z2 + longint'(center_q[2]));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random values
  // ---------------------------------------------------------------------------

  // Mostly modest coordinates, some full range, some corner values
  function automatic logic signed [CRD_W-1:0] random_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    if (pick < 8) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic vertex_t random_vertex();
    vertex_t v;
    v.vertex_x = random_coord();
    v.vertex_y = random_coord();
    v.vertex_z = random_coord();
    return v;
  endfunction

  function automatic logic [15:0] extreme_coef();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_cos_sin(setting_e kind);
    real ang;
    int  c, s;
    case (kind)
      SET_IDENTITY: return COS_SIN_RESET;
      SET_ANGLES: begin
        ang = real'($urandom_range(0, 35999)) * 3.14159265358979 / 18000.0;
        c = int'($cos(ang) * 16384.0);
        s = int'($sin(ang) * 16384.0);
        return {c[15:0], s[15:0]};
      end
      SET_RAW: return $urandom;
      default: return {extreme_coef(), extreme_coef()};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Leaves cfg_write high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_X_COS_SIN: axis_cs[0] = d;
      REG_Y_COS_SIN: axis_cs[1] = d;
      REG_Z_COS_SIN: axis_cs[2] = d;
      REG_CENTER_X:  center_q[0] = d;
      REG_CENTER_Y:  center_q[1] = d;
      REG_CENTER_Z:  center_q[2] = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering and wait until every outstanding word is back
  task automatic wait_drained();
    vertex_valid <= 1'b0;
    while (moved_expected.size() != 0) @(posedge clk);
  endtask

  task automatic load_setting(input logic [CFG_W-1:0] rx, ry, rz,
                              input logic signed [CRD_W-1:0] px, py, pz);
    wait_drained();
    write_reg(REG_X_COS_SIN, rx);
    write_reg(REG_Y_COS_SIN, ry);
    write_reg(REG_Z_COS_SIN, rz);
    write_reg(REG_CENTER_X, px);
    write_reg(REG_CENTER_Y, py);
    write_reg(REG_CENTER_Z, pz);
    cfg_write <= 1'b0;
  endtask

  // Offer one vertex, hold it until taken, then maybe leave a gap
  task automatic send_vertex(input vertex_t v);
    vertex_valid <= 1'b1;
    vertex       <= v;
    @(posedge clk);
    while (vertex_stall) @(posedge clk);
    moved_expected.push_back(rotate_about_center(v));
    if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      vertex_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_xyz(input logic signed [CRD_W-1:0] x, y, z);
    vertex_t v;
    v.vertex_x = x;
    v.vertex_y = y;
    v.vertex_z = z;
    send_vertex(v);
  endtask

  // ---------------------------------------------------------------------------
  // Output check and output stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : moved_check
    moved_t                  want;
    logic signed [CRD_W-1:0] want_f [3];
    logic signed [CRD_W-1:0] got_f [3];
    string                   names [3];
    int                      f;
    names = '{"moved_x", "moved_y", "moved_z"};
    if (rst) begin
      moved_stall <= 1'b0;
    end else begin
      if (moved_valid && !moved_stall) begin
        if (moved_expected.size() == 0) begin
          $display("%0t: moved word with none expected: %h", $time, moved);
          error_count++;
        end else begin
          want   = moved_expected.pop_front();
          want_f = '{want.moved_x, want.moved_y, want.moved_z};
          got_f  = '{moved.moved_x, moved.moved_y, moved.moved_z};
          for (f = 0; f < 3; f++) begin
            if (got_f[f] !== want_f[f]) begin
              $display("%0t: %s expected %0d (%h) got %0d (%h)", $time, names[f],
                       want_f[f], want_f[f], got_f[f], got_f[f]);
              error_count++;
            end
          end
        end
      end
      // stall for the next cycle: long hold-off first, then random bursts
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        moved_stall <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        moved_stall <= 1'b1;
        stall_left--;
      end else if (recv_gap_pct != 0 && $urandom_range(1, 100) <= recv_gap_pct) begin
        moved_stall <= 1'b1;
        stall_left = $urandom_range(0, 7);
      end else begin
        moved_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run after too long with no word moving
  always @(posedge clk) begin
    if ((vertex_valid && !vertex_stall) || (moved_valid && !moved_stall) || cfg_write) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("vertex_rotate_about_center_unit_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic apply_reset();
    axis_cs  = '{COS_SIN_RESET, COS_SIN_RESET, COS_SIN_RESET};
    center_q = '{32'sd0, 32'sd0, 32'sd0};
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_X_COS_SIN;
    cfg_data     <= '0;
    vertex_valid <= 1'b0;
    vertex       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // Reset values: identity rotation about the origin
  task automatic test_reset_identity();
    send_xyz(32'sd0, 32'sd0, 32'sd0);
    send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_xyz(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    send_xyz(32'h0001_8000, 32'hFFFE_0000, 32'h0003_4000);
  endtask

  // Quarter turns, first X alone, then all three about an offset center
  task automatic test_quarter_turns();
    load_setting(32'h0000_4000, COS_SIN_RESET, COS_SIN_RESET, 32'sd0, 32'sd0, 32'sd0);
    send_xyz(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_xyz(32'hFFFF_0000, 32'h0000_8000, 32'hFFFD_0000);
    load_setting(32'h0000_4000, 32'h0000_4000, 32'h0000_4000,
                 32'h0001_8000, 32'hFFFE_0000, 32'h0003_4000);
    send_xyz(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
  endtask

  // Coefficients of -2.0 and just under 2.0: wide intermediates, saturation
  task automatic test_extreme_coefficients();
    load_setting(32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    load_setting(32'h7FFF_7FFF, 32'h7FFF_8000, 32'h8000_7FFF, 32'sd0, 32'sd0, 32'sd0);
    send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
  endtask

  // cos 0.5 on X turns odd offsets into exact halves in both signs
  task automatic test_rounding_ties();
    load_setting(32'h2000_0000, COS_SIN_RESET, COS_SIN_RESET, 32'sd0, 32'sd0, 32'sd0);
    send_xyz(32'sd0, 32'sd1, -32'sd1);
    send_xyz(32'sd5, 32'sd3, -32'sd3);
    send_xyz(32'sd0, -32'sd7, 32'sd7);
  endtask

  // Writes to indexes with no register behind them change nothing
  task automatic test_unused_index();
    load_setting(32'h2D41_2D41, 32'h3B21_187E, 32'h0000_C000,
                 32'h0000_1000, 32'hFFFF_F000, 32'h0010_0000);
    @(posedge clk);
    write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_7, 32'h0000_0000);
    cfg_write <= 1'b0;
    send_xyz(32'h0004_0000, 32'hFFF0_0000, 32'h0001_2345);
    send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Random vertices under a sequence of settings, random idling both sides
  task automatic test_random_settings();
    setting_e plan [9] = '{SET_IDENTITY, SET_ANGLES, SET_ANGLES, SET_RAW, SET_EXTREME,
                           SET_ANGLES, SET_RAW, SET_EXTREME, SET_ANGLES};
    int p, k;
    for (p = 0; p < 9; p++) begin
      load_setting(random_cos_sin(plan[p]), random_cos_sin(plan[p]),
                   random_cos_sin(plan[p]), random_coord(), random_coord(),
                   random_coord());
      send_gap_pct = $urandom_range(0, 2) * 15;
      recv_gap_pct = $urandom_range(0, 2) * 15;
      for (k = 0; k < 150; k++) send_vertex(random_vertex());
    end
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_output_backpressure();
    int k;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_request = HOLD_OFF;
    for (k = 0; k < 48; k++) send_vertex(random_vertex());
  endtask

  // Sender stops until every word is back, then resumes
  task automatic test_sender_pause();
    int k;
    send_gap_pct = 20;
    recv_gap_pct = 20;
    for (k = 0; k < 30; k++) send_vertex(random_vertex());
    wait_drained();
    for (k = 0; k < 30; k++) send_vertex(random_vertex());
  endtask

  // No idling on either side to close the run
  task automatic test_full_rate();
    int k;
    load_setting(random_cos_sin(SET_ANGLES), random_cos_sin(SET_ANGLES),
                 random_cos_sin(SET_ANGLES), random_coord(), random_coord(),
                 random_coord());
    send_gap_pct = 0;
    recv_gap_pct = 0;
    for (k = 0; k < 200; k++) send_vertex(random_vertex());
  endtask

  initial begin
    apply_reset();
    test_reset_identity();
    test_quarter_turns();
    test_extreme_coefficients();
    test_rounding_ties();
    test_unused_index();
    test_random_settings();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("vertex_rotate_about_center_unit_tb: PASS");
    end else begin
      $display("vertex_rotate_about_center_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
